[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/svpe_pkg.sv]
// ----------------------------------------------------------------------------
// svpe_pkg
// Widths, reset values, codes and shared types of the servo position estimator.
// ----------------------------------------------------------------------------
package svpe_pkg;

  localparam int ANGLE_W   = 12;
  localparam int CMD_W     = 14;
  localparam int TIME_W    = 32;
  localparam int PULSE_W   = 15;
  localparam int MSPD_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam int DIV_DVD_W = 23;
  localparam int DIV_DVS_W = 8;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 12'd2880;
  localparam logic [ANGLE_W-1:0] ANGLE_MID = 12'd1440;
  localparam logic [DIV_DVS_W-1:0] FULL_DEG = 8'd180;

  localparam logic [MSPD_W-1:0]  MSPD_RST      = 8'd2;
  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 15'd500;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 15'd2900;
  localparam logic [PULSE_W-1:0] PULSE_MID_RST = 15'd1700;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_CMD  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MS_PER_DEG   = 2'd0,
    CFG_PULSE_MIN_US = 2'd1,
    CFG_PULSE_MAX_US = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [MSPD_W-1:0]  ms_per_deg;
    logic [PULSE_W-1:0] pulse_min_us;
    logic [PULSE_W-1:0] pulse_max_us;
  } cfg_t;

endpackage

[rtl/svpe_if.sv]
// ----------------------------------------------------------------------------
// svpe interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface svpe_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [svpe_pkg::CMD_W-1:0]   angle_cmd;
  logic        [svpe_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, action, angle_cmd, now_ms, input ready);
  modport sink   (input valid, action, angle_cmd, now_ms, output ready);
endinterface

interface svpe_out_if;
  logic                                valid;
  logic                                ready;
  logic [svpe_pkg::ANGLE_W-1:0]        est_angle;
  logic [svpe_pkg::ANGLE_W-1:0]        goal_angle;
  logic                                moving;
  logic [svpe_pkg::PULSE_W-1:0]        drive_us;

  modport source (output valid, est_angle, goal_angle, moving, drive_us, input ready);
  modport sink   (input valid, est_angle, goal_angle, moving, drive_us, output ready);
endinterface

interface svpe_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [svpe_pkg::CFG_IDX_W-1:0]      index;
  logic [svpe_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/servo_position_estimator_core.sv]
// ----------------------------------------------------------------------------
// servo_position_estimator_core
// Open-loop position estimate, move target and drive pulse of a hobby servo.
// ----------------------------------------------------------------------------
// Channels: cmd takes one item (action, angle_cmd, now_ms); res gives exactly
// one result per item (est_angle, goal_angle, moving, drive_us); cfg writes
// the travel rate and the pulse width limits by index, always ready.
// One item at a time: cmd.ready is high only while no item is in work.
// Path from the cmd transfer to res.valid:
//   command                - shared serial divider by 180 for the pulse
//   tick, no move          - straight to the result
//   tick, move finished    - through ST_TICK, which ends the move
//   tick, move in progress - through ST_TICK and the divider by the travel rate
// cmd.ready returns only after the res transfer.
// Reset: estimate and target go to 90 degrees, pulse to 1700 us, no move,
// registers to their defaults; res holds no result.
// A stalled res keeps its result and blocks the next cmd transfer.
// ----------------------------------------------------------------------------
module servo_position_estimator_core (
  input  logic        clk,
  input  logic        rst,
  svpe_in_if.sink     cmd,
  svpe_out_if.source  res,
  svpe_cfg_if.sink    cfg
);
  import svpe_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_TICK, ST_DIV, ST_OUT} state_t;

  state_t             state;
  cfg_t               regs;
  logic [ANGLE_W-1:0] est;
  logic [ANGLE_W-1:0] target;
  logic [ANGLE_W-1:0] origin;
  logic [TIME_W-1:0]  start_ms;
  logic [TIME_W-1:0]  elapsed;
  logic               moving;
  logic [PULSE_W-1:0] pulse;
  logic               op_cmd;

  logic               div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_DVS_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_DVD_W-1:0] div_q;

  logic               in_xfer;
  logic [ANGLE_W-1:0] clamped;
  logic [PULSE_W-1:0] span;
  logic [DIV_DVD_W-1:0] pulse_prod;
  logic               up;
  logic [ANGLE_W-1:0] travel;
  logic [ANGLE_W+MSPD_W-1:0] travel_prod;
  logic [TIME_W-1:0]  travel_ms;
  logic               move_over;
  logic [ANGLE_W-1:0] delta;

  svpe_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  svpe_div #(
    .DVD_W (DIV_DVD_W),
    .DVS_W (DIV_DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cmd.ready      = (state == ST_IDLE);
  assign in_xfer        = cmd.valid && cmd.ready;
  assign res.valid      = (state == ST_OUT);
  assign res.est_angle  = est;
  assign res.goal_angle = target;
  assign res.moving     = moving;
  assign res.drive_us   = pulse;

  always_comb begin
    if (cmd.angle_cmd[CMD_W-1]) begin
      clamped = '0;
    end else if (cmd.angle_cmd[CMD_W-2:0] > {1'b0, ANGLE_MAX}) begin
      clamped = ANGLE_MAX;
    end else begin
      clamped = cmd.angle_cmd[ANGLE_W-1:0];
    end
    span       = (regs.pulse_max_us > regs.pulse_min_us) ?
                 (regs.pulse_max_us - regs.pulse_min_us) : '0;
    pulse_prod = DIV_DVD_W'(clamped[ANGLE_W-1:4]) * DIV_DVD_W'(span);

    up          = (target >= origin);
    travel      = up ? (target - origin) : (origin - target);
    travel_prod = (ANGLE_W+MSPD_W)'(travel) * (ANGLE_W+MSPD_W)'(regs.ms_per_deg);
    travel_ms   = TIME_W'(travel_prod[ANGLE_W+MSPD_W-1:4]);
    move_over   = (elapsed >= travel_ms);
    delta       = (div_q > DIV_DVD_W'(travel)) ? travel : div_q[ANGLE_W-1:0];

    div_start    = 1'b0;
    div_dividend = pulse_prod;
    div_divisor  = FULL_DEG;
    if (state == ST_IDLE && in_xfer && cmd.action == ACT_CMD) begin
      div_start = 1'b1;
    end else if (state == ST_TICK && !move_over) begin
      div_start    = 1'b1;
      div_dividend = DIV_DVD_W'({elapsed[15:0], 4'b0000});
      div_divisor  = regs.ms_per_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      est      <= ANGLE_MID;
      target   <= ANGLE_MID;
      origin   <= ANGLE_MID;
      start_ms <= '0;
      moving   <= 1'b0;
      pulse    <= PULSE_MID_RST;
      op_cmd   <= 1'b0;
      elapsed  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            op_cmd  <= (cmd.action == ACT_CMD);
            elapsed <= cmd.now_ms - start_ms;
            if (cmd.action == ACT_CMD) begin
              origin   <= est;
              target   <= clamped;
              start_ms <= cmd.now_ms;
              moving   <= 1'b1;
              state    <= ST_DIV;
            end else if (moving) begin
              state <= ST_TICK;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_TICK: begin
          if (move_over) begin
            est    <= target;
            moving <= 1'b0;
            state  <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (op_cmd) begin
              pulse <= regs.pulse_min_us + div_q[PULSE_W-1:0];
            end else begin
              est <= up ? (origin + delta) : (origin - delta);
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/svpe_regs.sv]
// ----------------------------------------------------------------------------
// svpe_regs
// Configuration register file: travel rate and pulse width limits.
// ----------------------------------------------------------------------------
module svpe_regs (
  input  logic              clk,
  input  logic              rst,
  svpe_cfg_if.sink          cfg,
  output svpe_pkg::cfg_t    regs
);
  import svpe_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ms_per_deg   <= MSPD_RST;
      regs.pulse_min_us <= PULSE_MIN_RST;
      regs.pulse_max_us <= PULSE_MAX_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MS_PER_DEG:   regs.ms_per_deg   <= cfg.data[MSPD_W-1:0];
        CFG_PULSE_MIN_US: regs.pulse_min_us <= cfg.data[PULSE_W-1:0];
        CFG_PULSE_MAX_US: regs.pulse_max_us <= cfg.data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/svpe_div.sv]
// ----------------------------------------------------------------------------
// svpe_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svpe_div #(
  parameter int DVD_W = svpe_pkg::DIV_DVD_W,
  parameter int DVS_W = svpe_pkg::DIV_DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_diff;
  logic             qbit;

  always_comb begin
    rem_sh   = {rem, quotient[DVD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    qbit     = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_LAST;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= qbit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], qbit};
        cnt      <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/svpe_chk.sv]
// ----------------------------------------------------------------------------
// svpe_chk
// Port-level checks of the servo position estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svpe_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [svpe_pkg::ANGLE_W-1:0]  res_est_angle,
  input logic [svpe_pkg::ANGLE_W-1:0]  res_goal_angle,
  input logic                          res_moving,
  input logic [svpe_pkg::PULSE_W-1:0]  res_drive_us
);
  import svpe_pkg::*;

  logic                          cmd_xfer;
  logic                          res_stall;
  logic [2*ANGLE_W+PULSE_W:0]    res_q;
  logic                          angles_ok;
  logic                          at_goal;

  assign cmd_xfer  = cmd_valid && cmd_ready;
  assign res_stall = res_valid && !res_ready;
  assign res_q     = {res_est_angle, res_goal_angle, res_moving, res_drive_us};
  assign angles_ok = (res_est_angle <= ANGLE_MAX) && (res_goal_angle <= ANGLE_MAX);
  assign at_goal   = (res_est_angle == res_goal_angle);

  `CHK_ASSERT_ALWAYS(a_rst_no_result, clk, rst |=> !res_valid, "result after reset")

  `CHK_ASSERT(a_one_item, clk, rst, cmd_xfer |=> !cmd_ready, "item taken while busy")

  `CHK_ASSERT(a_hold, clk, rst, res_stall |=> (res_valid && $stable(res_q)), "held result changed")

  `CHK_ASSERT(a_range, clk, rst, res_valid |-> angles_ok, "angle out of range")

  `CHK_ASSERT(a_rest, clk, rst, (res_valid && !res_moving) |-> at_goal, "estimate off target")

endmodule

bind servo_position_estimator_core svpe_chk u_svpe_chk (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_est_angle  (res.est_angle),
  .res_goal_angle (res.goal_angle),
  .res_moving     (res.moving),
  .res_drive_us   (res.drive_us)
);
